/* rtl/ps2mc_pkg.sv */
// Package for the PS/2 mouse packet cursor block.
// Holds phase codes, register indexes and reset constants; no dependencies.
`timescale 1ns / 1ps
`default_nettype none
package ps2mc_pkg;

	// Packet byte phase
	typedef enum logic [1:0] {
		PH_BUTTONS = 2'd0,
		PH_X       = 2'd1,
		PH_Y       = 2'd2
	} phase_t;

	// Configuration register file
	localparam int CFG_W      = 12;
	localparam int CFG_IDX_W  = 1;
	localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = 1'd1;

	localparam logic [CFG_W-1:0] SCREEN_WIDTH_RST  = 12'd640;
	localparam logic [CFG_W-1:0] SCREEN_HEIGHT_RST = 12'd480;

	// Cursor geometry
	localparam int COORD_BITS_DEF = 12;
	localparam int POS_X_RST      = 320;
	localparam int POS_Y_RST      = 240;

	// Header byte layout
	localparam int BIT_LEFT   = 0;
	localparam int BIT_RIGHT  = 1;
	localparam int BIT_MIDDLE = 2;
	localparam int BIT_SIGN_X = 4;
	localparam int BIT_SIGN_Y = 5;

endpackage
`default_nettype wire

/* rtl/ps2_mouse_packet_cursor_core.sv */
// Top level of the PS/2 mouse packet decoder with a clamped cursor.
// Depends on ps2mc_pkg for phase codes, register indexes and reset values.
//
//  channel | signals                                   | direction | request
//  --------+-------------------------------------------+-----------+-----------------------
//  in      | in_valid, in_stall, packet_byte           | sink      | one raw mouse byte
//  out     | out_valid, out_stall, cursor_x, cursor_y, | source    | position, buttons and
//          | left/right/middle_button, packet_done     |           | packet-complete mark
//  cfg     | wr_en, wr_index, wr_data                  | sink      | clamp limit write
//
// Each request is decoded and the cursor moved in the cycle it is
// accepted, and the response shows in the output register on the next edge.
// One adder and one clamp compare are shared by both axes.
// A new request is taken every cycle while the output register is empty or drained.
// in_stall rises only while a response waits under out_stall.
// Reset drops the first byte, homes the cursor and restores the default limits.
`timescale 1ns / 1ps
`default_nettype none
module ps2_mouse_packet_cursor_core
	import ps2mc_pkg::*;
#(
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	// configuration
	input  wire logic                  wr_en,
	input  wire logic [CFG_IDX_W-1:0]  wr_index,
	input  wire logic [CFG_W-1:0]      wr_data,
	// input bytes
	input  wire logic                  in_valid,
	output logic                       in_stall,
	input  wire logic [7:0]            packet_byte,
	// results
	output logic                       out_valid,
	input  wire logic                  out_stall,
	output logic [COORD_BITS-1:0]      cursor_x,
	output logic [COORD_BITS-1:0]      cursor_y,
	output logic                       left_button,
	output logic                       right_button,
	output logic                       middle_button,
	output logic                       packet_done
);

	// Working width: holds the largest limit, a position and a signed 9-bit delta.
	localparam int SW = ((COORD_BITS > CFG_W) ? COORD_BITS : CFG_W) + 2;
	localparam logic [SW-1:0] COORD_MAX = SW'((64'd1 << COORD_BITS) - 64'd1);

	// Limits
	logic [CFG_W-1:0] screen_width_q;
	logic [CFG_W-1:0] screen_height_q;

	// Decoder state; the position and button registers double as the response payload
	phase_t                phase_q, phase_d;
	logic                  skip_done_q;
	logic [COORD_BITS-1:0] pos_x_q, pos_y_q;
	logic [2:0]            buttons_q;
	logic                  sign_x_q, sign_y_q;
	logic                  out_valid_q;
	logic                  packet_done_q;

	logic accept;

	// Shared axis datapath
	logic                  move_y;
	logic [COORD_BITS-1:0] pos_sel;
	logic                  sign_sel;
	logic [CFG_W-1:0]      size_sel;
	logic [SW-1:0]         size_ext;
	logic signed [SW-1:0]  limit;
	logic signed [SW-1:0]  delta;
	logic signed [SW-1:0]  sum;
	logic [COORD_BITS-1:0] pos_new;
	logic                  move_x_en, move_y_en, hdr_en, done_d;

	// Take a request whenever the output register is free or drains this edge
	assign in_stall = out_valid_q & out_stall;
	assign accept   = in_valid & ~in_stall;

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			screen_width_q  <= SCREEN_WIDTH_RST;
			screen_height_q <= SCREEN_HEIGHT_RST;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_SCREEN_WIDTH:  screen_width_q  <= wr_data;
				REG_SCREEN_HEIGHT: screen_height_q <= wr_data;
				default: ;
			endcase
		end
	end

	// Phase sequencing: the first byte after reset is dropped and leaves the phase alone
	always_comb begin
		phase_d   = phase_q;
		move_x_en = 1'b0;
		move_y_en = 1'b0;
		hdr_en    = 1'b0;
		done_d    = 1'b0;
		if (skip_done_q) begin
			unique case (phase_q)
				PH_X: begin
					move_x_en = 1'b1;
					phase_d   = PH_Y;
				end
				PH_Y: begin
					move_y_en = 1'b1;
					done_d    = 1'b1;
					phase_d   = PH_BUTTONS;
				end
				default: begin
					// header byte; the unused code is handled the same way
					hdr_en  = 1'b1;
					phase_d = PH_X;
				end
			endcase
		end
	end

	// Pick the axis, add the sign-extended byte and saturate to [0, limit]
	assign move_y   = (phase_q == PH_Y);
	assign pos_sel  = move_y ? pos_y_q  : pos_x_q;
	assign sign_sel = move_y ? sign_y_q : sign_x_q;
	assign size_sel = move_y ? screen_height_q : screen_width_q;
	assign size_ext = SW'(size_sel);
	assign limit    = $signed((size_ext > COORD_MAX) ? COORD_MAX : size_ext);
	assign delta    = $signed({{(SW-8){sign_sel}}, packet_byte});
	assign sum      = $signed(SW'(pos_sel)) + delta;

	always_comb begin
		priority if (sum > limit) begin
			pos_new = COORD_BITS'(limit);
		end else if (sum[SW-1]) begin
			pos_new = '0;
		end else begin
			pos_new = COORD_BITS'(sum);
		end
	end

	// State and response register, advanced on each accepted request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_BUTTONS;
			skip_done_q   <= 1'b0;
			pos_x_q       <= COORD_BITS'(POS_X_RST);
			pos_y_q       <= COORD_BITS'(POS_Y_RST);
			buttons_q     <= '0;
			sign_x_q      <= 1'b0;
			sign_y_q      <= 1'b0;
			packet_done_q <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			if (accept) begin
				phase_q       <= phase_d;
				skip_done_q   <= 1'b1;
				packet_done_q <= done_d;
				if (move_x_en) begin
					pos_x_q <= pos_new;
				end
				if (move_y_en) begin
					pos_y_q <= pos_new;
				end
				if (hdr_en) begin
					buttons_q <= {packet_byte[BIT_MIDDLE], packet_byte[BIT_RIGHT],
						packet_byte[BIT_LEFT]};
					sign_x_q  <= packet_byte[BIT_SIGN_X];
					sign_y_q  <= packet_byte[BIT_SIGN_Y];
				end
			end
			// hold while stalled, drop once taken
			if (accept) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid     = out_valid_q;
	assign cursor_x      = pos_x_q;
	assign cursor_y      = pos_y_q;
	assign left_button   = buttons_q[0];
	assign right_button  = buttons_q[1];
	assign middle_button = buttons_q[2];
	assign packet_done   = packet_done_q;

	// A waiting response must back-pressure the input side
	a_stall_back: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |-> in_stall)
		else $error("response waiting but input not stalled");

	// Every accepted request yields a response on the next edge
	a_resp_follows: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> out_valid)
		else $error("accepted request produced no response");

	// A completed packet always leaves the decoder back at the header phase
	a_done_phase: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && packet_done |-> phase_q == PH_BUTTONS && skip_done_q)
		else $error("packet done outside header phase");

	// An accepted Y-byte request always completes the packet
	a_done_src: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && skip_done_q && phase_q == PH_Y |=> packet_done)
		else $error("Y byte did not complete the packet");

endmodule
`default_nettype wire
